@@ src/spd_pkg.sv @@
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the shortest path block.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int NODE_W   = 6;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 22;
    localparam int VCNT_W   = 7;

    localparam logic CFG_VERTEX_COUNT  = 1'b0;
    localparam logic CFG_SOURCE_VERTEX = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] weight;
        logic                carries_edge;
        logic                last_edge;
    } edge_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] vertex;
        logic [DIST_W-1:0] distance;
        logic              reachable;
        logic              last_vertex;
        logic              edges_dropped;
    } dist_item_t;

    // Classified command passed from front to back.
    typedef struct packed {
        logic                store;
        logic                drop;
        logic                start_run;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] weight;
    } spd_cmd_t;

endpackage

@@ src/spd_front.sv @@
// ----------------------------------------------------------------------------
// spd_front
// Accepts input transfers, checks endpoints and queues commands (2 deep).
// ----------------------------------------------------------------------------
module spd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  spd_pkg::edge_item_t data,
    input  logic [6:0]         n_eff,
    output logic               cmd_valid,
    input  logic               cmd_take,
    output spd_pkg::spd_cmd_t  cmd
);
    import spd_pkg::*;

    spd_cmd_t   q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg;
    logic       wr_ptr;
    logic       push, pop;
    logic       bad;
    spd_cmd_t   c;

    assign stall     = (cnt_reg == 2'd2);
    assign push      = valid && !stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = q_reg[rd_reg];
    assign wr_ptr    = rd_reg ^ cnt_reg[0];

    always_comb
    begin
        bad         = ({1'b0, data.node_a} >= n_eff) || ({1'b0, data.node_b} >= n_eff);
        c.store     = data.carries_edge && !bad;
        c.drop      = data.carries_edge && bad;
        c.start_run = data.last_edge;
        c.node_a    = data.node_a;
        c.node_b    = data.node_b;
        c.weight    = data.weight;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

endmodule

@@ src/spd_back.sv @@
// ----------------------------------------------------------------------------
// spd_back
// Edge store, Dijkstra sequencer and result output register.
// ----------------------------------------------------------------------------
module spd_back #(
    parameter int VERTICES   = 64,
    parameter int EDGE_SLOTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_take,
    input  spd_pkg::spd_cmd_t  cmd,
    input  logic [6:0]         n_eff,
    input  logic [5:0]         src,
    output logic               valid,
    input  logic               stall,
    output spd_pkg::dist_item_t data
);
    import spd_pkg::*;

    localparam int EA_W = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
    localparam int ET_W = $clog2(EDGE_SLOTS + 1);
    localparam int VI_W = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam logic [DIST_W:0] INF = '1;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_PICK   = 9'b000000100,
        S_EREAD  = 9'b000001000,
        S_RELAX  = 9'b000010000,
        S_OUT    = 9'b000100000,
        S_INIT   = 9'b001000000,
        S_TREAD  = 9'b010000000,
        S_OREAD  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [2*NODE_W+WEIGHT_W-1:0] mem [EDGE_SLOTS];
    logic [2*NODE_W+WEIGHT_W-1:0] mrd_reg;
    logic [ET_W-1:0]   etot_reg;
    logic              drop_reg;
    logic [DIST_W:0]   best_reg [VERTICES];
    logic [DIST_W:0]   bd_q_reg;
    logic [VERTICES-1:0] settled_reg;
    logic [6:0]        vi_reg;
    logic [ET_W-1:0]   ei_reg;
    logic [DIST_W:0]   minv_reg;
    logic [DIST_W:0]   pickd_reg;
    logic [6:0]        pick_reg;
    logic [6:0]        iter_reg;
    logic [6:0]        n_reg;
    logic              ovalid_reg;
    dist_item_t        odata_reg;

    logic [NODE_W-1:0] ea, eb;
    logic [WEIGHT_W-1:0] ew;
    logic [DIST_W:0]   cand;
    logic [NODE_W-1:0] tgt;
    logic              do_rel;
    logic              out_free;
    logic              has_edge;
    logic [6:0]        vprev;
    logic [VI_W-1:0]   bd_addr;

    assign {ea, eb, ew} = mrd_reg;
    assign valid    = ovalid_reg;
    assign data     = odata_reg;
    assign out_free = !ovalid_reg || !stall;
    assign cmd_take = (state_reg == S_IDLE);
    assign has_edge = ei_reg < etot_reg;
    assign vprev    = vi_reg - 7'd1;
    assign bd_addr  = (state_reg == S_TREAD) ? tgt[VI_W-1:0] : vi_reg[VI_W-1:0];

    always_comb
    begin
        cand   = pickd_reg + {{(DIST_W+1-WEIGHT_W){1'b0}}, ew};
        tgt    = (ea == pick_reg[NODE_W-1:0]) ? eb : ea;
        do_rel = ({1'b0, ea} < n_reg) && ({1'b0, eb} < n_reg)
                 && ((ea == pick_reg[NODE_W-1:0]) || (eb == pick_reg[NODE_W-1:0]))
                 && !settled_reg[tgt[VI_W-1:0]] && (cand < bd_q_reg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid && cmd.store && etot_reg != ET_W'(EDGE_SLOTS))
        begin
            mem[etot_reg[EA_W-1:0]] <= {cmd.node_a, cmd.node_b, cmd.weight};
        end
        mrd_reg <= mem[ei_reg[EA_W-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd.start_run)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (vi_reg == 7'(VERTICES - 1))
                begin
                    state_next = ({1'b0, src} < n_reg) ? S_SCAN : S_OREAD;
                end
            end
            S_SCAN:
            begin
                if (vi_reg == n_reg)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                state_next = (minv_reg == INF || iter_reg == n_reg) ? S_OREAD : S_EREAD;
            end
            S_EREAD:
            begin
                state_next = has_edge ? S_TREAD : S_SCAN;
            end
            S_TREAD:
            begin
                state_next = S_RELAX;
            end
            S_RELAX:
            begin
                state_next = S_EREAD;
            end
            S_OREAD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = (vi_reg == n_reg - 7'd1) ? S_IDLE : S_OREAD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // distance memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
        begin
            best_reg[vi_reg[VI_W-1:0]] <= ({1'b0, src} == vi_reg) ? '0 : INF;
        end
        else if (state_reg == S_RELAX && do_rel)
        begin
            best_reg[tgt[VI_W-1:0]] <= cand;
        end
        bd_q_reg <= best_reg[bd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            etot_reg    <= '0;
            drop_reg    <= 1'b0;
            settled_reg <= '0;
            vi_reg      <= '0;
            ei_reg      <= '0;
            minv_reg    <= INF;
            pickd_reg   <= '0;
            pick_reg    <= '0;
            iter_reg    <= '0;
            n_reg       <= 7'd1;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!stall)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    vi_reg   <= '0;
                    iter_reg <= '0;
                    n_reg    <= n_eff;
                    if (cmd_valid)
                    begin
                        if (cmd.store)
                        begin
                            if (etot_reg == ET_W'(EDGE_SLOTS))
                            begin
                                drop_reg <= 1'b1;
                            end
                            else
                            begin
                                etot_reg <= etot_reg + ET_W'(1);
                            end
                        end
                        if (cmd.drop)
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                end
                S_INIT:
                begin
                    settled_reg[vi_reg[VI_W-1:0]] <= 1'b0;
                    vi_reg   <= (vi_reg == 7'(VERTICES - 1)) ? 7'd0 : vi_reg + 7'd1;
                    minv_reg <= INF;
                end
                S_SCAN:
                begin
                    // read data is registered, so it belongs to the previous address
                    if (vi_reg != 7'd0 && !settled_reg[vprev[VI_W-1:0]]
                        && bd_q_reg < minv_reg)
                    begin
                        minv_reg <= bd_q_reg;
                        pick_reg <= vprev;
                    end
                    vi_reg <= vi_reg + 7'd1;
                end
                S_PICK:
                begin
                    vi_reg    <= '0;
                    ei_reg    <= '0;
                    pickd_reg <= minv_reg;
                    if (minv_reg != INF && iter_reg != n_reg)
                    begin
                        settled_reg[pick_reg[VI_W-1:0]] <= 1'b1;
                        iter_reg <= iter_reg + 7'd1;
                    end
                end
                S_EREAD:
                begin
                    minv_reg <= INF;
                    vi_reg   <= '0;
                end
                S_RELAX:
                begin
                    ei_reg <= ei_reg + ET_W'(1);
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        odata_reg.vertex        <= vi_reg[NODE_W-1:0];
                        odata_reg.reachable     <= (bd_q_reg != INF);
                        odata_reg.distance      <= (bd_q_reg != INF) ? bd_q_reg[DIST_W-1:0] : '0;
                        odata_reg.last_vertex   <= (vi_reg == n_reg - 7'd1);
                        odata_reg.edges_dropped <= drop_reg;
                        vi_reg <= vi_reg + 7'd1;
                        if (vi_reg == n_reg - 7'd1)
                        begin
                            etot_reg <= '0;
                            drop_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ src/shortest_path_dijkstra.sv @@
// ----------------------------------------------------------------------------
// shortest_path_dijkstra
// Loads undirected edges, then reports shortest distances from a source.
//
//   channel   signals                      dir
//   in        in_valid in_stall in_data    edge items
//   out       out_valid out_stall out_data one per vertex after a solve
//   cfg       cfg_we cfg_index cfg_data    vertex_count, source_vertex
//
// Edges load at one per cycle while the solver is idle, through a two-entry
// command queue; input stalls once the queue is full. A solve clears all
// VERTICES distances, then per pick runs a serial min scan over the vertices
// and walks the edge store. Results are read in S_OREAD, then registered in
// S_OUT when out_stall is low. Reset clears counters and flags, not the store.
// ----------------------------------------------------------------------------
module shortest_path_dijkstra #(
    parameter int VERTICES   = 64,
    parameter int EDGE_SLOTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  spd_pkg::edge_item_t in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output spd_pkg::dist_item_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [6:0]          cfg_data
);
    import spd_pkg::*;

    logic [VCNT_W-1:0] vcnt_reg;
    logic [NODE_W-1:0] src_reg;
    logic [6:0]        n_eff;
    logic              cmd_valid, cmd_take;
    spd_cmd_t          cmd;

    always_comb
    begin
        if (vcnt_reg == '0)
            n_eff = 7'd1;
        else if (vcnt_reg > 7'(VERTICES))
            n_eff = 7'(VERTICES);
        else
            n_eff = vcnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg <= 7'd64;
            src_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT:  vcnt_reg <= cfg_data;
                CFG_SOURCE_VERTEX: src_reg  <= cfg_data[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    spd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .stall     (in_stall),
        .data      (in_data),
        .n_eff     (n_eff),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    spd_back #(
        .VERTICES   (VERTICES),
        .EDGE_SLOTS (EDGE_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .n_eff     (n_eff),
        .src       (src_reg),
        .valid     (out_valid),
        .stall     (out_stall),
        .data      (out_data)
    );

endmodule
